// ----- hdl/ais_pkg.sv -----
// Shared types and constants for the ascending integer sorter.
// Used by ais_front, ais_queue, ais_back and ascending_integer_sorter.
package ais_pkg;

    localparam int VALUE_W       = 32;
    localparam int MAX_ITEMS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      keep;
        logic                      end_of_run;
        logic                      overflow;
    } ais_entry_t;

    typedef enum logic {
        AIS_LOAD,
        AIS_DRAIN
    } ais_state_t;

endpackage

// ----- hdl/ais_front.sv -----
// Input stage of the sorter: accepts beats, counts the run, marks drops.
// Depends on ais_pkg.
module ais_front #(
    parameter int MAX_ITEMS = ais_pkg::MAX_ITEMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [ais_pkg::VALUE_W-1:0] value,
    input  logic                               end_of_run,
    input  logic                               q_full,
    output logic                               push,
    output ais_pkg::ais_entry_t                entry
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          dropped_reg;
    logic          dropped_next;
    logic          accepted;
    logic          keep;

    assign in_stall = q_full;
    assign accepted = in_valid && !q_full;
    assign keep     = count_reg < CW'(MAX_ITEMS);

    always_comb
    begin
        entry.value      = value;
        entry.keep       = keep;
        entry.end_of_run = end_of_run;
        entry.overflow   = dropped_reg || !keep;
        push             = accepted && (keep || end_of_run);
        count_next       = count_reg;
        dropped_next     = dropped_reg;
        if (accepted)
        begin
            if (end_of_run)
            begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            else if (keep)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("run count beyond capacity");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accepted && !end_of_run && !keep) |=> dropped_reg)
        else $error("dropped beat not recorded");

    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accepted && end_of_run) |=> (count_reg == '0) && !dropped_reg)
        else $error("run state not cleared at end of run");

endmodule

// ----- hdl/ais_queue.sv -----
// Short queue of classified entries between the input stage and the sort chain.
// Depends on ais_pkg.
module ais_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ais_pkg::ais_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output ais_pkg::ais_entry_t head
);

    localparam int PW = (ais_pkg::QUEUE_DEPTH > 1) ? $clog2(ais_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(ais_pkg::QUEUE_DEPTH + 1);

    ais_pkg::ais_entry_t slot_reg [ais_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] fill_reg;
    logic [NW-1:0] fill_next;
    logic          do_push;
    logic          do_pop;

    assign full    = fill_reg == NW'(ais_pkg::QUEUE_DEPTH);
    assign q_valid = fill_reg != '0;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        fill_next = fill_reg;
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + NW'(1);
            2'b01:   fill_next = fill_reg - NW'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(ais_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(ais_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + PW'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- hdl/ais_back.sv -----
// Systolic insertion chain: inserts one entry a cycle, then shifts the run out
// in ascending order through an output register. Depends on ais_pkg.
module ais_back #(
    parameter int MAX_ITEMS = ais_pkg::MAX_ITEMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  ais_pkg::ais_entry_t                head,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ais_pkg::VALUE_W-1:0] sorted_value,
    output logic                               last_result,
    output logic                               overflow
);

    localparam logic [MAX_ITEMS-1:0] ONE_V = {{(MAX_ITEMS-1){1'b0}}, 1'b1};

    ais_pkg::ais_state_t state_reg;
    ais_pkg::ais_state_t state_next;

    logic signed [ais_pkg::VALUE_W-1:0] cell_val_reg  [MAX_ITEMS];
    logic signed [ais_pkg::VALUE_W-1:0] cell_val_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]               cell_vld_reg;
    logic [MAX_ITEMS-1:0]               cell_vld_next;
    logic [MAX_ITEMS-1:0]               gt;

    logic                               run_ovf_reg;
    logic                               run_ovf_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [ais_pkg::VALUE_W-1:0] sorted_value_reg;
    logic                               last_result_reg;
    logic                               overflow_reg;
    logic                               load_out;
    logic                               insert;

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign last_result  = last_result_reg;
    assign overflow     = overflow_reg;

    always_comb
    begin
        state_next     = state_reg;
        run_ovf_next   = run_ovf_reg;
        pop            = 1'b0;
        insert         = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ais_pkg::AIS_LOAD:
            begin
                pop    = q_valid;
                insert = q_valid && head.keep;
                if (q_valid && head.end_of_run)
                begin
                    state_next   = ais_pkg::AIS_DRAIN;
                    run_ovf_next = head.overflow;
                end
            end
            ais_pkg::AIS_DRAIN:
            begin
                load_out = !out_valid_reg || !out_stall;
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    if (!cell_vld_reg[1])
                    begin
                        state_next = ais_pkg::AIS_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ais_pkg::AIS_LOAD;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            gt[i]            = !cell_vld_reg[i] || (cell_val_reg[i] > head.value);
            cell_val_next[i] = cell_val_reg[i];
        end
        cell_vld_next = cell_vld_reg;
        if (insert)
        begin
            cell_val_next[0] = gt[0] ? head.value : cell_val_reg[0];
            cell_vld_next[0] = 1'b1;
            for (int i = 1; i < MAX_ITEMS; i++)
            begin
                if (gt[i])
                begin
                    cell_val_next[i] = gt[i-1] ? cell_val_reg[i-1] : head.value;
                end
                cell_vld_next[i] = cell_vld_reg[i] || cell_vld_reg[i-1];
            end
        end
        else if (load_out)
        begin
            for (int i = 0; i < MAX_ITEMS - 1; i++)
            begin
                cell_val_next[i] = cell_val_reg[i+1];
            end
            cell_vld_next = cell_vld_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            cell_val_reg[i] <= cell_val_next[i];
        end
        if (load_out)
        begin
            sorted_value_reg <= cell_val_reg[0];
            last_result_reg  <= !cell_vld_reg[1];
            overflow_reg     <= run_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ais_pkg::AIS_LOAD;
            cell_vld_reg  <= '0;
            run_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cell_vld_reg  <= cell_vld_next;
            run_ovf_reg   <= run_ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ais_pkg::AIS_DRAIN) |-> cell_vld_reg[0])
        else $error("drain with empty chain");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        insert |-> !cell_vld_reg[MAX_ITEMS-1])
        else $error("insert into full chain");

    a_vld_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_vld_reg & (cell_vld_reg + ONE_V)) == '0)
        else $error("chain occupancy not contiguous");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !cell_vld_reg[1]) |=> (cell_vld_reg == '0))
        else $error("chain not empty after final result");

endmodule

// ----- hdl/ascending_integer_sorter.sv -----
// Sorts runs of signed 32-bit values into ascending order. Depends on ais_pkg,
// ais_front, ais_queue and ais_back.
//
// Values arrive one beat per cycle while in_stall is low, with end_of_run on the
// final beat of a run. Up to MAX_ITEMS values of a run are kept; later ones are
// dropped and every result of that run has overflow set. Each kept value enters
// a systolic insertion chain of MAX_ITEMS cells, so a run loads at one beat per
// cycle while in_stall is low. After the end_of_run beat has reached the chain,
// the run leaves in ascending order at one result per cycle while out_stall is
// low, through an output register, with last_result on the largest. While the
// chain drains, a two-entry queue takes the first beats of the next run; after
// that the input stalls until the chain is empty. An accepted input beat is
// registered in the queue, then enters the chain from the head of the queue.
module ascending_integer_sorter #(
    parameter int MAX_ITEMS = ais_pkg::MAX_ITEMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [ais_pkg::VALUE_W-1:0] value,
    input  logic                               end_of_run,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ais_pkg::VALUE_W-1:0] sorted_value,
    output logic                               last_result,
    output logic                               overflow
);

    ais_pkg::ais_entry_t push_entry;
    ais_pkg::ais_entry_t head;
    logic                push;
    logic                q_full;
    logic                q_valid;
    logic                pop;

    ais_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .end_of_run (end_of_run),
        .q_full     (q_full),
        .push       (push),
        .entry      (push_entry)
    );

    ais_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head)
    );

    ais_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_result  (last_result),
        .overflow     (overflow)
    );

endmodule
